[rtl/cit_pkg.sv]
// cit_pkg: shared types, codes and count helpers for the cascaded interval timer
// no dependencies
`timescale 1ns / 1ps

package cit_pkg;

    localparam int CHAN_COUNT = 3;
    localparam int COUNT_W    = 17;

    typedef logic signed [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MIN = 17'sh10000;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic [1:0] SEL_CTRL  = 2'd3;
    localparam logic [1:0] RW_LATCH  = 2'd0;
    localparam logic [2:0] MODE_ZERO = 3'd0;
    localparam logic [2:0] MODE_RATE = 3'd2;

    typedef struct packed {
        logic       start_pending;
        logic       running;
        logic [2:0] mode;
        count_t     count;
        logic [15:0] reload;
        count_t     latched;
        logic       latch_held;
        logic       ptr_high;
        logic [7:0] low_byte;
    } chan_t;

    // saturating decrement
    function automatic count_t cit_dec(input count_t c);
        count_t r;
        r = (c == COUNT_MIN) ? c : c - 17'sd1;
        return r;
    endfunction

    function automatic logic cit_expired(input count_t c, input logic [2:0] mode);
        logic r;
        r = (c <= 17'sd0) || ((c <= 17'sd1) && (mode == MODE_RATE));
        return r;
    endfunction

endpackage

[rtl/cascaded_interval_timer.sv]
// cascaded_interval_timer: three-channel timer behind four byte registers
// depends on cit_pkg
//
// channel | ports          | tdata (low bit up)          | tuser (low bit up)
// input   | s_tvalid/tready| write_data[7:0]             | opcode[1:0], reg_select[3:2]
// result  | m_tvalid/tready| read_data[7:0], irq[8], 0s  | -
//
// one beat in, one beat out; a beat moves from the input register into the result
// register once the result register is empty or being read
// a new beat is taken every cycle unless stalled; channel state updates as a beat advances
// reset clears all channel state and the valid flags of both registers
// a stalled result holds the pipe; the input register still fills behind it
`timescale 1ns / 1ps

module cascaded_interval_timer
    import cit_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // write_data[7:0]
    input  logic [3:0]  s_tuser,   // opcode[1:0], reg_select[3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[7:0], irq[8], zero fill
);

    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_op_reg;
    logic [1:0]  in_sel_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_rd_reg, out_rd_next;
    logic        out_irq_reg, out_irq_next;
    chan_t       chan_reg  [CHAN_COUNT];
    chan_t       chan_next [CHAN_COUNT];

    logic        s_accept;
    logic        advance;
    logic [1:0]  ctrl_ch;
    count_t      snap;
    count_t      dec1;
    count_t      dec2;
    logic        exp1;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign ctrl_ch  = in_data_reg[7:6];

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_comb begin
        for (int i = 0; i < CHAN_COUNT; i++) begin
            chan_next[i] = chan_reg[i];
        end
        out_rd_next  = 8'd0;
        out_irq_next = 1'b0;
        snap         = '0;
        dec1         = '0;
        dec2         = '0;
        exp1         = 1'b0;

        case (opcode_t'(in_op_reg))
            OP_READ: begin
                for (int i = 0; i < CHAN_COUNT; i++) begin
                    if (in_sel_reg == 2'(i)) begin
                        snap = chan_reg[i].latch_held ? chan_reg[i].latched : chan_reg[i].count;
                        chan_next[i].latched = snap;
                        if (chan_reg[i].ptr_high) begin
                            out_rd_next = snap[15:8];
                            chan_next[i].latch_held = 1'b0;
                        end else begin
                            out_rd_next = snap[7:0];
                        end
                        chan_next[i].ptr_high = !chan_reg[i].ptr_high;
                    end
                end
            end
            OP_WRITE: begin
                for (int i = 0; i < CHAN_COUNT; i++) begin
                    if (in_sel_reg == 2'(i)) begin
                        if (chan_reg[i].ptr_high) begin
                            chan_next[i].reload = {in_data_reg, chan_reg[i].low_byte};
                            if (chan_reg[i].mode == MODE_ZERO) begin
                                chan_next[i].running       = 1'b0;
                                chan_next[i].start_pending = 1'b1;
                            end else if (!chan_reg[i].running) begin
                                chan_next[i].start_pending = 1'b1;
                            end
                        end else begin
                            chan_next[i].low_byte = in_data_reg;
                        end
                        chan_next[i].ptr_high = !chan_reg[i].ptr_high;
                    end
                    if (in_sel_reg == SEL_CTRL && ctrl_ch == 2'(i)) begin
                        if (in_data_reg[5:4] == RW_LATCH) begin
                            chan_next[i].latched    = chan_reg[i].count;
                            chan_next[i].latch_held = 1'b1;
                        end else begin
                            chan_next[i].latch_held    = 1'b0;
                            chan_next[i].mode          = in_data_reg[3:1];
                            chan_next[i].start_pending = 1'b0;
                            chan_next[i].running       = 1'b0;
                            chan_next[i].reload        = 16'd0;
                        end
                    end
                end
            end
            OP_TICK: begin
                for (int i = 0; i < CHAN_COUNT; i++) begin
                    if (chan_reg[i].start_pending && !chan_reg[i].running) begin
                        chan_next[i].start_pending = 1'b0;
                        chan_next[i].running       = 1'b1;
                        chan_next[i].count         = count_t'({1'b0, chan_reg[i].reload});
                    end
                end
                dec1 = cit_dec(chan_next[1].count);
                exp1 = cit_expired(dec1, chan_next[1].mode);
                if (chan_next[1].running) begin
                    chan_next[1].count = exp1 ? count_t'({1'b0, chan_next[1].reload}) : dec1;
                    if (exp1 && chan_next[2].running) begin
                        dec2 = cit_dec(chan_next[2].count);
                        chan_next[2].count = dec2;
                        out_irq_next = cit_expired(dec2, chan_next[2].mode);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHAN_COUNT; i++) begin
                chan_reg[i] <= '0;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                for (int i = 0; i < CHAN_COUNT; i++) begin
                    chan_reg[i] <= chan_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_tuser[1:0];
            in_sel_reg  <= s_tuser[3:2];
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_rd_reg  <= out_rd_next;
            out_irq_reg <= out_irq_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_irq_reg, out_rd_reg};

    // a held input beat is never dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input beat lost while stalled");

    // interrupt only from a tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg != OP_TICK |=> !out_irq_reg)
        else $error("irq raised by a non-tick beat");

    // read data only from a read
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg != OP_READ |=> out_rd_reg == 8'd0)
        else $error("read data on a non-read beat");

    // after a tick no channel is left armed and idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_op_reg == OP_TICK |=>
            !(chan_reg[0].start_pending && !chan_reg[0].running) &&
            !(chan_reg[1].start_pending && !chan_reg[1].running) &&
            !(chan_reg[2].start_pending && !chan_reg[2].running))
        else $error("armed channel not started by tick");

endmodule
